// ===== rtl/core/ths_pkg.sv =====
// ----------------------------------------------------------------------------
// ths_pkg
// Shared constants for the terrain height sampler: grid limits, field widths,
// action codes and configuration register indexes.
// ----------------------------------------------------------------------------
package ths_pkg;

  localparam int MAX_COLUMNS = 256;
  localparam int MAX_ROWS    = 256;

  // Grid store addressing and cell index widths
  localparam int ADDR_W = $clog2(MAX_COLUMNS * MAX_ROWS);
  localparam int CX_W   = $clog2(MAX_COLUMNS);
  localparam int CZ_W   = $clog2(MAX_ROWS);

  localparam int HEIGHT_W = 32;
  localparam int COUNT_W  = 9;
  localparam int CFG_IDX_W = 3;

  // Q1.16 unit weight (1.0)
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // Action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_PER_UNIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS      = 3'd4;

  localparam logic [COUNT_W-1:0] MAX_COLUMNS_C = COUNT_W'(MAX_COLUMNS);
  localparam logic [COUNT_W-1:0] MAX_ROWS_C    = COUNT_W'(MAX_ROWS);

endpackage

// ===== rtl/core/ths_grid_ram.sv =====
// ----------------------------------------------------------------------------
// ths_grid_ram
// One write port, two registered read ports, with a shared read enable.
// ----------------------------------------------------------------------------
module ths_grid_ram #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [DATA_W-1:0] rdata_a,
  output logic [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [0:(1<<ADDR_W)-1];

  // Store one word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read two words, held while the read side stalls
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== rtl/core/terrain_height_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// terrain_height_sampler_unit
// Heightmap store with barycentric height queries in Q16.16.
// ----------------------------------------------------------------------------
// The unit takes one beat per cycle when not stalled, writes and queries
// mixed freely, and returns one result beat per query (writes give none).
// A query passes through eight register stages: origin subtract, scale
// multiply, cell range check, corner addressing, grid read, weight
// multiply, sum, and the rounding and saturating output register. Each
// stage moves on when the one after it has room, so bubbles close up and
// a stalled output holds only as many beats as the pipeline has stages.
// The grid is kept in two identical copies, each with two read ports, so
// the four corners of a cell are read in the same cycle. Writes land at
// the read stage in beat order, so a query sees every earlier write. The
// grid has no reset: reading a vertex never written gives an unknown
// height. Configuration writes are taken at any time with cfg_ready held
// high but belong between bursts, with the pipeline empty.
// ----------------------------------------------------------------------------
module terrain_height_sampler_unit (
  input  logic        clk,
  input  logic        rst,
  // Configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // Input beats
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [15:0] vertex_index,
  input  logic signed [31:0] vertex_height,
  input  logic signed [31:0] query_x,
  input  logic signed [31:0] query_z,
  // Result beats
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] sampled_height,
  output logic        outside
);

  // Configuration registers
  logic signed [31:0]                 origin_x;
  logic signed [31:0]                 origin_z;
  logic [31:0]                        cells_per_unit;
  logic [ths_pkg::COUNT_W-1:0]        grid_columns;
  logic [ths_pkg::COUNT_W-1:0]        grid_rows;
  logic [ths_pkg::COUNT_W-1:0]        cols_sat;
  logic [ths_pkg::COUNT_W-1:0]        rows_sat;

  assign cfg_ready = 1'b1;

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x       <= '0;
      origin_z       <= '0;
      cells_per_unit <= 32'h0001_0000;
      grid_columns   <= ths_pkg::MAX_COLUMNS_C;
      grid_rows      <= ths_pkg::MAX_ROWS_C;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ths_pkg::REG_ORIGIN_X:       origin_x       <= cfg_data;
        ths_pkg::REG_ORIGIN_Z:       origin_z       <= cfg_data;
        ths_pkg::REG_CELLS_PER_UNIT: cells_per_unit <= cfg_data;
        ths_pkg::REG_GRID_COLUMNS:   grid_columns   <= cfg_data[ths_pkg::COUNT_W-1:0];
        ths_pkg::REG_GRID_ROWS:      grid_rows      <= cfg_data[ths_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the counts in use to the store's size
  assign cols_sat = (grid_columns > ths_pkg::MAX_COLUMNS_C) ? ths_pkg::MAX_COLUMNS_C
                                                            : grid_columns;
  assign rows_sat = (grid_rows > ths_pkg::MAX_ROWS_C) ? ths_pkg::MAX_ROWS_C : grid_rows;

  // Stage valids and load enables (index 7 is the output register)
  logic [6:0] v;
  logic [7:0] en;

  always_comb begin
    en[7] = !out_valid || out_ready;
    for (int k = 6; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  // Stage payloads
  logic                             act0, act1, act2, act3;
  logic [15:0]                      vidx0, vidx1, vidx2, vidx3;
  logic [31:0]                      vh0, vh1, vh2, vh3;
  logic signed [32:0]               dx0, dz0;
  logic [63:0]                      px1, pz1;
  logic                             neg1;
  logic                             out2, out3, out4, out5, out6;
  logic [ths_pkg::CX_W-1:0]         cx2;
  logic [ths_pkg::CZ_W-1:0]         cz2;
  logic [15:0]                      fx2, fz2, fx3, fz3;
  logic [ths_pkg::ADDR_W-1:0]       a_tl3, a_tr3, a_bl3, a_br3;
  logic                             act4, lower4;
  logic [16:0]                      w0_4, w1_4, w2_4;
  logic [31:0]                      tl4, tr4, bl4, br4, tl4b, tr4b;
  logic signed [49:0]               m0_5, m1_5, m2_5;
  logic signed [51:0]               acc6;

  // Stage 0: take the beat, subtract the origin
  always_ff @(posedge clk) begin
    if (en[0]) begin
      act0  <= action;
      vidx0 <= vertex_index;
      vh0   <= vertex_height;
      dx0   <= {query_x[31], query_x} - {origin_x[31], origin_x};
      dz0   <= {query_z[31], query_z} - {origin_z[31], origin_z};
    end
  end

  // Stage 1: scale by cells per unit; negative offsets clamp to zero
  logic [31:0] ux, uz;
  logic        cpu_zero;
  assign cpu_zero = (cells_per_unit == 32'd0);
  assign ux = dx0[32] ? 32'd0 : dx0[31:0];
  assign uz = dz0[32] ? 32'd0 : dz0[31:0];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      act1  <= act0;
      vidx1 <= vidx0;
      vh1   <= vh0;
      px1   <= {32'd0, ux} * {32'd0, cells_per_unit};
      pz1   <= {32'd0, uz} * {32'd0, cells_per_unit};
      neg1  <= (dx0[32] || dz0[32]) && !cpu_zero;
    end
  end

  // Stage 2: split cell and fraction, check the cell range
  logic out_next2;
  always_comb begin
    out_next2 = neg1 || (cols_sat < 9'd2) || (rows_sat < 9'd2)
             || (({1'b0, px1[63:32]} + 33'd2) > {24'd0, cols_sat})
             || (({1'b0, pz1[63:32]} + 33'd2) > {24'd0, rows_sat});
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      act2  <= act1;
      vidx2 <= vidx1;
      vh2   <= vh1;
      out2  <= out_next2;
      cx2   <= px1[32 +: ths_pkg::CX_W];
      cz2   <= pz1[32 +: ths_pkg::CZ_W];
      fx2   <= px1[31:16];
      fz2   <= pz1[31:16];
    end
  end

  // Stage 3: form the four corner addresses
  logic [ths_pkg::ADDR_W+1:0] base3;
  assign base3 = (ths_pkg::ADDR_W+2)'(cz2 * cols_sat) + (ths_pkg::ADDR_W+2)'(cx2);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      act3  <= act2;
      vidx3 <= vidx2;
      vh3   <= vh2;
      out3  <= out2;
      fx3   <= fx2;
      fz3   <= fz2;
      a_tl3 <= base3[ths_pkg::ADDR_W-1:0];
      a_tr3 <= ths_pkg::ADDR_W'(base3 + 1'b1);
      a_bl3 <= ths_pkg::ADDR_W'(base3 + cols_sat);
      a_br3 <= ths_pkg::ADDR_W'(base3 + cols_sat + 1'b1);
    end
  end

  // Stage 4: read the corners, store writes, pick triangle and weights
  logic        we3;
  logic [16:0] fsum3;
  assign we3   = en[4] && v[3] && (act3 == ths_pkg::ACT_WRITE);
  assign fsum3 = {1'b0, fx3} + {1'b0, fz3};

  ths_grid_ram #(.ADDR_W(ths_pkg::ADDR_W), .DATA_W(ths_pkg::HEIGHT_W)) u_ram_top (
    .clk     (clk),
    .we      (we3),
    .waddr   (vidx3[ths_pkg::ADDR_W-1:0]),
    .wdata   (vh3),
    .re      (en[4]),
    .raddr_a (a_tl3),
    .raddr_b (a_tr3),
    .rdata_a (tl4),
    .rdata_b (tr4)
  );

  ths_grid_ram #(.ADDR_W(ths_pkg::ADDR_W), .DATA_W(ths_pkg::HEIGHT_W)) u_ram_bot (
    .clk     (clk),
    .we      (we3),
    .waddr   (vidx3[ths_pkg::ADDR_W-1:0]),
    .wdata   (vh3),
    .re      (en[4]),
    .raddr_a (a_bl3),
    .raddr_b (a_br3),
    .rdata_a (bl4),
    .rdata_b (br4)
  );

  assign tl4b = tl4;
  assign tr4b = tr4;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      act4   <= act3;
      out4   <= out3;
      lower4 <= !fsum3[16];
      if (!fsum3[16]) begin
        w0_4 <= ths_pkg::ONE_Q16 - fsum3;
        w1_4 <= {1'b0, fx3};
        w2_4 <= {1'b0, fz3};
      end else begin
        w0_4 <= fsum3 - ths_pkg::ONE_Q16;
        w1_4 <= ths_pkg::ONE_Q16 - {1'b0, fz3};
        w2_4 <= ths_pkg::ONE_Q16 - {1'b0, fx3};
      end
    end
  end

  // Stage 5: weight the three corners
  logic signed [31:0] h0_4;
  assign h0_4 = lower4 ? tl4b : br4;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      out5 <= out4;
      m0_5 <= 50'(h0_4 * $signed({1'b0, w0_4}));
      m1_5 <= 50'($signed(tr4b) * $signed({1'b0, w1_4}));
      m2_5 <= 50'($signed(bl4) * $signed({1'b0, w2_4}));
    end
  end

  // Stage 6: sum
  always_ff @(posedge clk) begin
    if (en[6]) begin
      out6 <= out5;
      acc6 <= 52'(m0_5) + 52'(m1_5) + 52'(m2_5);
    end
  end

  // Output register: round half up, saturate
  logic signed [51:0] rnd6;
  logic signed [35:0] res6;
  logic signed [31:0] sat6;
  assign rnd6 = acc6 + 52'sd32768;
  assign res6 = rnd6[51:16];
  always_comb begin
    if (res6 > 36'sd2147483647) begin
      sat6 = 32'sh7FFF_FFFF;
    end else if (res6 < -36'sd2147483648) begin
      sat6 = 32'sh8000_0000;
    end else begin
      sat6 = res6[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      sampled_height <= out6 ? 32'sd0 : sat6;
      outside        <= out6;
    end
  end

  // Advance valids; writes drop out after the grid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
      if (en[3]) v[3] <= v[2];
      if (en[4]) v[4] <= v[3];
      if (en[5]) v[5] <= v[4] && (act4 == ths_pkg::ACT_QUERY);
      if (en[6]) v[6] <= v[5];
      if (en[7]) out_valid <= v[6];
    end
  end

  // An outside result carries a zero height
  assert property (@(posedge clk) disable iff (rst)
    out_valid && outside |-> sampled_height == 32'sd0)
    else $error("outside result with nonzero height");

  // Input stalls only when every stage is full and the output is held
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready && (v == 7'h7F))
    else $error("input stalled with room in the pipeline");

  // A finished sum moving on becomes a result beat
  assert property (@(posedge clk) disable iff (rst)
    v[6] && en[7] |=> out_valid)
    else $error("result beat lost at output");

  // No grid write while the pipeline stalls at the read stage
  assert property (@(posedge clk) disable iff (rst)
    we3 |-> en[4] && v[3])
    else $error("grid write outside a moving write beat");

endmodule
